### design/mtac_pkg.sv
// mtac_pkg: shared types and constants for the multi-turn angle counter
// no dependencies; used by the channel interfaces, the top level and the checker

package mtac_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned RawWidth      = 2 * ByteWidth;
   localparam int unsigned DegWidth      = 13;
   localparam int unsigned QuadWidth     = 3;

   // raw * 360 / 4096 == (raw * 45) >> 9
   localparam int unsigned DegMult       = 360 / 8;
   localparam int unsigned DegShift      = 12 - 3;
   localparam int unsigned ProdWidth     = RawWidth + 6;

   localparam int unsigned QuadBound1    = 90;
   localparam int unsigned QuadBound2    = 180;
   localparam int unsigned QuadBound3    = 270;
   localparam int unsigned FullTurn      = 360;
   localparam int unsigned DegMax        = 5759;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [ByteWidth-1:0] CODE_HIGH  = 8'h01;
   localparam logic [ByteWidth-1:0] CODE_LOW   = 8'h02;
   localparam logic [ByteWidth-1:0] CODE_TURNS = 8'h03;

   localparam logic [QuadWidth-1:0] QUAD_NONE = 3'd0;
   localparam logic [QuadWidth-1:0] QUAD_1    = 3'd1;
   localparam logic [QuadWidth-1:0] QUAD_2    = 3'd2;
   localparam logic [QuadWidth-1:0] QUAD_3    = 3'd3;
   localparam logic [QuadWidth-1:0] QUAD_4    = 3'd4;

   typedef struct packed {
      logic                 opcode;
      logic [ByteWidth-1:0] angle_high;
      logic [ByteWidth-1:0] angle_low;
      logic [ByteWidth-1:0] request_code;
   } req_type;

   typedef struct packed {
      logic [ByteWidth-1:0] reply_byte;
      logic [DegWidth-1:0]  angle_degrees;
      logic [ByteWidth-1:0] turn_count;
      logic [QuadWidth-1:0] quadrant_now;
   } rsp_type;

endpackage

### design/mtac_if.sv
// mtac channel interfaces: valid/ready handshake with request and result payloads
// depends on mtac_pkg

interface mtac_req_if;
   logic                           valid;
   logic                           ready;
   logic                           opcode;
   logic [mtac_pkg::ByteWidth-1:0] angle_high;
   logic [mtac_pkg::ByteWidth-1:0] angle_low;
   logic [mtac_pkg::ByteWidth-1:0] request_code;

   modport source (output valid, opcode, angle_high, angle_low, request_code, input ready);
   modport sink   (input valid, opcode, angle_high, angle_low, request_code, output ready);
endinterface

interface mtac_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mtac_pkg::ByteWidth-1:0] reply_byte;
   logic [mtac_pkg::DegWidth-1:0]  angle_degrees;
   logic [mtac_pkg::ByteWidth-1:0] turn_count;
   logic [mtac_pkg::QuadWidth-1:0] quadrant_now;

   modport source (output valid, reply_byte, angle_degrees, turn_count, quadrant_now,
                   input ready);
   modport sink   (input valid, reply_byte, angle_degrees, turn_count, quadrant_now,
                   output ready);
endinterface

### design/multi_turn_angle_counter.sv
// multi_turn_angle_counter: angle samples to degrees, quadrant and turn count, plus reads
// depends on mtac_pkg and the channel interfaces in mtac_if.sv
//
// One result item per request item, in order. An item is taken in every cycle while the
// skid register is empty; the state update and the result are done in the cycle of
// acceptance. Results sit in an output register plus one skid register, which takes
// a result while the output one waits, so a waiting result does not stop the next item.

module multi_turn_angle_counter (
   input  logic       clock,
   input  logic       reset,
   mtac_req_if.sink   req_ch,
   mtac_rsp_if.source rsp_ch
);

   logic [mtac_pkg::ByteWidth-1:0] high_byte_ff, high_byte_in;
   logic [mtac_pkg::ByteWidth-1:0] low_byte_ff, low_byte_in;
   logic [mtac_pkg::ByteWidth-1:0] turns_ff, turns_in;
   logic [mtac_pkg::QuadWidth-1:0] quadrant_ff, quadrant_in;
   logic [mtac_pkg::QuadWidth-1:0] prev_quadrant_ff, prev_quadrant_in;
   logic [mtac_pkg::DegWidth-1:0]  last_degrees_ff, last_degrees_in;

   mtac_pkg::rsp_type out_ff, out_in, skid_ff, skid_in, result;
   logic              out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic                             push, pop;
   logic [mtac_pkg::RawWidth-1:0]    raw;
   logic [mtac_pkg::ProdWidth-1:0]   prod;
   logic [mtac_pkg::DegWidth-1:0]    deg;
   logic [mtac_pkg::QuadWidth-1:0]   quad_new;
   logic [mtac_pkg::ByteWidth-1:0]   reply;

   assign req_ch.ready = !skid_valid_ff;
   assign push         = req_ch.valid && req_ch.ready;
   assign pop          = out_valid_ff && rsp_ch.ready;

   // degrees, truncated to whole degrees
   assign raw  = {req_ch.angle_high, req_ch.angle_low};
   assign prod = mtac_pkg::ProdWidth'(raw) * mtac_pkg::ProdWidth'(mtac_pkg::DegMult);
   assign deg  = prod[mtac_pkg::DegShift +: mtac_pkg::DegWidth];

   always_comb begin
      if (deg <= mtac_pkg::DegWidth'(mtac_pkg::QuadBound1)) begin
         quad_new = mtac_pkg::QUAD_1;
      end else if (deg <= mtac_pkg::DegWidth'(mtac_pkg::QuadBound2)) begin
         quad_new = mtac_pkg::QUAD_2;
      end else if (deg <= mtac_pkg::DegWidth'(mtac_pkg::QuadBound3)) begin
         quad_new = mtac_pkg::QUAD_3;
      end else if (deg < mtac_pkg::DegWidth'(mtac_pkg::FullTurn)) begin
         quad_new = mtac_pkg::QUAD_4;
      end else begin
         quad_new = quadrant_ff;
      end
   end

   always_comb begin
      case (req_ch.request_code)
         mtac_pkg::CODE_HIGH:  reply = high_byte_ff;
         mtac_pkg::CODE_LOW:   reply = low_byte_ff;
         mtac_pkg::CODE_TURNS: reply = turns_ff;
         default:              reply = req_ch.request_code;
      endcase
   end

   // state update
   always_comb begin
      high_byte_in     = high_byte_ff;
      low_byte_in      = low_byte_ff;
      turns_in         = turns_ff;
      quadrant_in      = quadrant_ff;
      prev_quadrant_in = prev_quadrant_ff;
      last_degrees_in  = last_degrees_ff;
      if (push && req_ch.opcode == mtac_pkg::OP_SAMPLE) begin
         high_byte_in    = req_ch.angle_high;
         low_byte_in     = req_ch.angle_low;
         last_degrees_in = deg;
         quadrant_in     = quad_new;
         if (quad_new != prev_quadrant_ff) begin
            if (quad_new == mtac_pkg::QUAD_1 && prev_quadrant_ff == mtac_pkg::QUAD_4) begin
               turns_in = turns_ff + 8'd1;
            end
            if (quad_new == mtac_pkg::QUAD_4 && prev_quadrant_ff == mtac_pkg::QUAD_1) begin
               turns_in = turns_ff - 8'd1;
            end
            prev_quadrant_in = quad_new;
         end
      end
   end

   always_comb begin
      result.reply_byte    = (req_ch.opcode == mtac_pkg::OP_READ) ? reply : '0;
      result.angle_degrees = last_degrees_in;
      result.turn_count    = turns_in;
      result.quadrant_now  = quadrant_in;
   end

   // output register and skid register
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_byte_ff     <= '0;
         low_byte_ff      <= '0;
         turns_ff         <= '0;
         quadrant_ff      <= mtac_pkg::QUAD_NONE;
         prev_quadrant_ff <= mtac_pkg::QUAD_NONE;
         last_degrees_ff  <= '0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         high_byte_ff     <= high_byte_in;
         low_byte_ff      <= low_byte_in;
         turns_ff         <= turns_in;
         quadrant_ff      <= quadrant_in;
         prev_quadrant_ff <= prev_quadrant_in;
         last_degrees_ff  <= last_degrees_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.reply_byte    = out_ff.reply_byte;
   assign rsp_ch.angle_degrees = out_ff.angle_degrees;
   assign rsp_ch.turn_count    = out_ff.turn_count;
   assign rsp_ch.quadrant_now  = out_ff.quadrant_now;

endmodule

### design/mtac_checker.sv
// mtac_checker: port-level checks on the multi-turn angle counter, bound to the top level
// depends on mtac_pkg and multi_turn_angle_counter

module mtac_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [mtac_pkg::ByteWidth-1:0] reply_byte,
   input logic [mtac_pkg::DegWidth-1:0]  angle_degrees,
   input logic [mtac_pkg::ByteWidth-1:0] turn_count,
   input logic [mtac_pkg::QuadWidth-1:0] quadrant_now
);

   // stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(reply_byte)
         && $stable(angle_degrees) && $stable(turn_count) && $stable(quadrant_now))
      else $error("stalled result item changed");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result item right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> quadrant_now <= mtac_pkg::QUAD_4
         && angle_degrees <= mtac_pkg::DegWidth'(mtac_pkg::DegMax))
      else $error("quadrant or degrees out of range");

   // no turns can be counted before the first quadrant
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && quadrant_now == mtac_pkg::QUAD_NONE |-> turn_count == '0
         && angle_degrees >= mtac_pkg::DegWidth'(mtac_pkg::FullTurn) || angle_degrees == '0)
      else $error("turns or degrees without a quadrant");

endmodule

bind multi_turn_angle_counter mtac_checker u_mtac_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .reply_byte    (rsp_ch.reply_byte),
   .angle_degrees (rsp_ch.angle_degrees),
   .turn_count    (rsp_ch.turn_count),
   .quadrant_now  (rsp_ch.quadrant_now)
);
